// File: rtl/spi_pkg.sv
`timescale 1ns / 1ps

package spi_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  typedef enum logic [1:0] {
    HIT_NONE  = 2'd0,
    HIT_START = 2'd1,
    HIT_END   = 2'd2,
    HIT_CROSS = 2'd3
  } hit_kind_e;

  typedef enum logic [1:0] {
    REG_NORMAL_X = 2'd0,
    REG_NORMAL_Y = 2'd1,
    REG_NORMAL_Z = 2'd2,
    REG_OFFSET   = 2'd3
  } cfg_reg_e;

  // Width of a signed plane distance: three full products or the shifted
  // offset, whichever is wider, plus headroom for the sum.
  function automatic int dist_width(input int cw, input int fb);
    int w;
    w = (2 * cw > cw + fb) ? 2 * cw : cw + fb;
    return w + 2;
  endfunction

endpackage

// File: rtl/spi_dist.sv
`timescale 1ns / 1ps

module spi_dist #(
  parameter int CW = spi_pkg::COORD_WIDTH,
  parameter int FB = spi_pkg::FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic signed [CW-1:0] seg_start_i [3],
  input  logic signed [CW-1:0] seg_end_i [3],
  input  logic signed [CW-1:0] normal_i [3],
  input  logic signed [CW-1:0] offset_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic signed [CW-1:0] seg_start_o [3],
  output logic signed [CW-1:0] seg_end_o [3],
  output logic signed [spi_pkg::dist_width(CW, FB)-1:0] ds_o,
  output logic signed [spi_pkg::dist_width(CW, FB)-1:0] de_o
);

  localparam int DW = spi_pkg::dist_width(CW, FB);
  localparam int PW = 2 * CW;

  logic                 a_valid_q, b_valid_q;
  logic                 a_en, b_en;
  logic signed [PW-1:0] prod_s_q [3];
  logic signed [PW-1:0] prod_e_q [3];
  logic signed [DW-1:0] off_q;
  logic signed [CW-1:0] a_ps_q [3];
  logic signed [CW-1:0] a_pe_q [3];
  logic signed [CW-1:0] b_ps_q [3];
  logic signed [CW-1:0] b_pe_q [3];
  logic signed [DW-1:0] ds_q, ds_d, de_q, de_d;

  assign b_en    = !b_valid_q || ready_i;
  assign a_en    = !a_valid_q || b_en;
  assign ready_o = a_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_en) a_valid_q <= valid_i;
      if (b_en) b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_en) begin
      for (int i = 0; i < 3; i++) begin
        prod_s_q[i] <= PW'(normal_i[i]) * PW'(seg_start_i[i]);
        prod_e_q[i] <= PW'(normal_i[i]) * PW'(seg_end_i[i]);
        a_ps_q[i]   <= seg_start_i[i];
        a_pe_q[i]   <= seg_end_i[i];
      end
      off_q <= DW'(offset_i) <<< FB;
    end
  end

  always_comb begin
    ds_d = off_q;
    de_d = off_q;
    for (int i = 0; i < 3; i++) begin
      ds_d = ds_d + DW'(prod_s_q[i]);
      de_d = de_d + DW'(prod_e_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_en) begin
      ds_q   <= ds_d;
      de_q   <= de_d;
      b_ps_q <= a_ps_q;
      b_pe_q <= a_pe_q;
    end
  end

  assign valid_o     = b_valid_q;
  assign ds_o        = ds_q;
  assign de_o        = de_q;
  assign seg_start_o = b_ps_q;
  assign seg_end_o   = b_pe_q;

endmodule

// File: rtl/spi_blend.sv
`timescale 1ns / 1ps

module spi_blend #(
  parameter int CW = spi_pkg::COORD_WIDTH,
  parameter int FB = spi_pkg::FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic signed [CW-1:0] seg_start_i [3],
  input  logic signed [CW-1:0] seg_end_i [3],
  input  logic signed [spi_pkg::dist_width(CW, FB)-1:0] ds_i,
  input  logic signed [spi_pkg::dist_width(CW, FB)-1:0] de_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output spi_pkg::hit_kind_e   kind_o,
  output logic signed [CW-1:0] point_o [3],
  output logic [spi_pkg::dist_width(CW, FB)+CW:0] den_o,
  output logic [spi_pkg::dist_width(CW, FB)+CW:0] mag_o [3],
  output logic                 neg_o [3]
);

  localparam int NW  = spi_pkg::dist_width(CW, FB);
  localparam int HW  = (NW + 1) / 2;
  localparam int LPW = HW + 1 + CW;
  localparam int HPW = NW - HW + 1 + CW;
  localparam int RW  = NW + CW + 1;

  logic c_valid_q, d_valid_q, e_valid_q, f_valid_q;
  logic c_en, d_en, e_en, f_en;

  spi_pkg::hit_kind_e   c_kind_q, d_kind_q, e_kind_q, f_kind_q, kind_d;
  logic signed [CW-1:0] c_pt_q [3];
  logic signed [CW-1:0] d_pt_q [3];
  logic signed [CW-1:0] e_pt_q [3];
  logic signed [CW-1:0] f_pt_q [3];
  logic signed [CW-1:0] c_ps_q [3];
  logic signed [CW-1:0] c_pe_q [3];
  logic [NW-1:0]        ns_q, ne_q, ns_d, ne_d;
  logic [NW:0]          c_den_q, d_den_q, e_den_q, f_den_q;
  logic signed [LPW-1:0] a_lo_q [3];
  logic signed [LPW-1:0] b_lo_q [3];
  logic signed [HPW-1:0] a_hi_q [3];
  logic signed [HPW-1:0] b_hi_q [3];
  logic signed [RW-1:0] num_q [3];
  logic [RW-1:0]        mag_q [3];
  logic                 neg_q [3];
  logic                 s_zero, e_zero;

  assign f_en    = !f_valid_q || ready_i;
  assign e_en    = !e_valid_q || f_en;
  assign d_en    = !d_valid_q || e_en;
  assign c_en    = !c_valid_q || d_en;
  assign ready_o = c_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
      f_valid_q <= 1'b0;
    end else begin
      if (c_en) c_valid_q <= valid_i;
      if (d_en) d_valid_q <= c_valid_q;
      if (e_en) e_valid_q <= d_valid_q;
      if (f_en) f_valid_q <= e_valid_q;
    end
  end

  assign s_zero = (ds_i == '0);
  assign e_zero = (de_i == '0);
  assign ns_d   = ds_i[NW-1] ? NW'(~ds_i + 1'b1) : NW'(ds_i);
  assign ne_d   = de_i[NW-1] ? NW'(~de_i + 1'b1) : NW'(de_i);

  always_comb begin
    if (!s_zero && !e_zero && (ds_i[NW-1] == de_i[NW-1])) begin
      kind_d = spi_pkg::HIT_NONE;
    end else if (s_zero) begin
      kind_d = spi_pkg::HIT_START;
    end else if (e_zero) begin
      kind_d = spi_pkg::HIT_END;
    end else begin
      kind_d = spi_pkg::HIT_CROSS;
    end
  end

  // Stage C: classify, take magnitudes and pick the endpoint for the easy cases.
  always_ff @(posedge clk_i) begin
    if (c_en) begin
      c_kind_q <= kind_d;
      ns_q     <= ns_d;
      ne_q     <= ne_d;
      c_den_q  <= {1'b0, ns_d} + {1'b0, ne_d};
      c_ps_q   <= seg_start_i;
      c_pe_q   <= seg_end_i;
      for (int i = 0; i < 3; i++) begin
        case (kind_d)
          spi_pkg::HIT_START: c_pt_q[i] <= seg_start_i[i];
          spi_pkg::HIT_END:   c_pt_q[i] <= seg_end_i[i];
          default:            c_pt_q[i] <= '0;
        endcase
      end
    end
  end

  // Stage D: partial products of the wide weights with the coordinates.
  always_ff @(posedge clk_i) begin
    if (d_en) begin
      d_kind_q <= c_kind_q;
      d_pt_q   <= c_pt_q;
      d_den_q  <= c_den_q;
      for (int i = 0; i < 3; i++) begin
        a_lo_q[i] <= $signed({1'b0, ns_q[HW-1:0]}) * c_pe_q[i];
        a_hi_q[i] <= $signed({1'b0, ns_q[NW-1:HW]}) * c_pe_q[i];
        b_lo_q[i] <= $signed({1'b0, ne_q[HW-1:0]}) * c_ps_q[i];
        b_hi_q[i] <= $signed({1'b0, ne_q[NW-1:HW]}) * c_ps_q[i];
      end
    end
  end

  // Stage E: blended numerator per axis.
  always_ff @(posedge clk_i) begin
    if (e_en) begin
      e_kind_q <= d_kind_q;
      e_pt_q   <= d_pt_q;
      e_den_q  <= d_den_q;
      for (int i = 0; i < 3; i++) begin
        num_q[i] <= (RW'(a_hi_q[i]) <<< HW) + RW'(a_lo_q[i])
                  + (RW'(b_hi_q[i]) <<< HW) + RW'(b_lo_q[i]);
      end
    end
  end

  // Stage F: sign and magnitude for the divider.
  always_ff @(posedge clk_i) begin
    if (f_en) begin
      f_kind_q <= e_kind_q;
      f_pt_q   <= e_pt_q;
      f_den_q  <= e_den_q;
      for (int i = 0; i < 3; i++) begin
        neg_q[i] <= num_q[i][RW-1];
        mag_q[i] <= num_q[i][RW-1] ? (~num_q[i] + 1'b1) : num_q[i];
      end
    end
  end

  assign valid_o = f_valid_q;
  assign kind_o  = f_kind_q;
  assign point_o = f_pt_q;
  assign den_o   = RW'(f_den_q);
  assign mag_o   = mag_q;
  assign neg_o   = neg_q;

endmodule

// File: rtl/spi_div_step.sv
`timescale 1ns / 1ps

module spi_div_step #(
  parameter int CW  = spi_pkg::COORD_WIDTH,
  parameter int RW  = 2 * spi_pkg::COORD_WIDTH,
  parameter int BIT = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  spi_pkg::hit_kind_e   kind_i,
  input  logic signed [CW-1:0] point_i [3],
  input  logic [RW-1:0]        den_i,
  input  logic [RW-1:0]        rem_i [3],
  input  logic [CW-1:0]        quo_i [3],
  input  logic                 neg_i [3],
  output logic                 valid_o,
  input  logic                 ready_i,
  output spi_pkg::hit_kind_e   kind_o,
  output logic signed [CW-1:0] point_o [3],
  output logic [RW-1:0]        den_o,
  output logic [RW-1:0]        rem_o [3],
  output logic [CW-1:0]        quo_o [3],
  output logic                 neg_o [3]
);

  logic                 valid_q, en;
  spi_pkg::hit_kind_e   kind_q;
  logic signed [CW-1:0] point_q [3];
  logic [RW-1:0]        den_q, trial;
  logic [RW-1:0]        rem_q [3];
  logic [CW-1:0]        quo_q [3];
  logic                 neg_q [3];

  assign en      = !valid_q || ready_i;
  assign ready_o = en;
  assign trial   = den_i << BIT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  // One restoring step: quotient bit BIT of each axis.
  always_ff @(posedge clk_i) begin
    if (en) begin
      kind_q  <= kind_i;
      point_q <= point_i;
      den_q   <= den_i;
      neg_q   <= neg_i;
      for (int i = 0; i < 3; i++) begin
        if (rem_i[i] >= trial) begin
          rem_q[i] <= rem_i[i] - trial;
          quo_q[i] <= quo_i[i] | (CW'(1) << BIT);
        end else begin
          rem_q[i] <= rem_i[i];
          quo_q[i] <= quo_i[i];
        end
      end
    end
  end

  assign valid_o = valid_q;
  assign kind_o  = kind_q;
  assign point_o = point_q;
  assign den_o   = den_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign neg_o   = neg_q;

endmodule

// File: rtl/segment_plane_intersection_unit.sv
`timescale 1ns / 1ps
// Pipeline: two distance stages, four blend stages, one restoring divider step per
// quotient bit, and the output register. Throughput: one segment per cycle while
// out_stall_i is low. Reset clears every valid bit and loads the plane registers
// with normal (0, 0, 1.0) and offset 0.

module segment_plane_intersection_unit #(
  parameter int COORD_WIDTH = spi_pkg::COORD_WIDTH,
  parameter int FRAC_BITS   = spi_pkg::FRAC_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_index_i,
  input  logic [COORD_WIDTH-1:0] cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] start_x_i,
  input  logic signed [COORD_WIDTH-1:0] start_y_i,
  input  logic signed [COORD_WIDTH-1:0] start_z_i,
  input  logic signed [COORD_WIDTH-1:0] end_x_i,
  input  logic signed [COORD_WIDTH-1:0] end_y_i,
  input  logic signed [COORD_WIDTH-1:0] end_z_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             hit_kind_o,
  output logic signed [COORD_WIDTH-1:0] point_x_o,
  output logic signed [COORD_WIDTH-1:0] point_y_o,
  output logic signed [COORD_WIDTH-1:0] point_z_o
);

  localparam int CW = COORD_WIDTH;
  localparam int NW = spi_pkg::dist_width(COORD_WIDTH, FRAC_BITS);
  localparam int RW = NW + CW + 1;

  logic signed [CW-1:0] normal_q [3];
  logic signed [CW-1:0] offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_q[0] <= '0;
      normal_q[1] <= '0;
      normal_q[2] <= CW'(64'd1 << FRAC_BITS);
      offset_q    <= '0;
    end else if (cfg_valid_i) begin
      case (spi_pkg::cfg_reg_e'(cfg_index_i))
        spi_pkg::REG_NORMAL_X: normal_q[0] <= cfg_data_i;
        spi_pkg::REG_NORMAL_Y: normal_q[1] <= cfg_data_i;
        spi_pkg::REG_NORMAL_Z: normal_q[2] <= cfg_data_i;
        spi_pkg::REG_OFFSET:   offset_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  logic signed [CW-1:0] seg_start [3];
  logic signed [CW-1:0] seg_end [3];
  logic signed [CW-1:0] dist_ps [3];
  logic signed [CW-1:0] dist_pe [3];
  logic signed [NW-1:0] ds, de;
  logic                 in_ready, dist_valid, dist_ready;

  assign seg_start[0] = start_x_i;
  assign seg_start[1] = start_y_i;
  assign seg_start[2] = start_z_i;
  assign seg_end[0]   = end_x_i;
  assign seg_end[1]   = end_y_i;
  assign seg_end[2]   = end_z_i;
  assign in_stall_o   = !in_ready;

  spi_dist #(.CW(CW), .FB(FRAC_BITS)) u_dist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid_i),
    .ready_o     (in_ready),
    .seg_start_i (seg_start),
    .seg_end_i   (seg_end),
    .normal_i    (normal_q),
    .offset_i    (offset_q),
    .valid_o     (dist_valid),
    .ready_i     (dist_ready),
    .seg_start_o (dist_ps),
    .seg_end_o   (dist_pe),
    .ds_o        (ds),
    .de_o        (de)
  );

  logic                 div_valid [CW+1];
  logic                 div_ready [CW+1];
  spi_pkg::hit_kind_e   div_kind [CW+1];
  logic signed [CW-1:0] div_pt [CW+1][3];
  logic [RW-1:0]        div_den [CW+1];
  logic [RW-1:0]        div_rem [CW+1][3];
  logic [CW-1:0]        div_quo [CW+1][3];
  logic                 div_neg [CW+1][3];

  spi_blend #(.CW(CW), .FB(FRAC_BITS)) u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (dist_valid),
    .ready_o     (dist_ready),
    .seg_start_i (dist_ps),
    .seg_end_i   (dist_pe),
    .ds_i        (ds),
    .de_i        (de),
    .valid_o     (div_valid[0]),
    .ready_i     (div_ready[0]),
    .kind_o      (div_kind[0]),
    .point_o     (div_pt[0]),
    .den_o       (div_den[0]),
    .mag_o       (div_rem[0]),
    .neg_o       (div_neg[0])
  );

  assign div_quo[0][0] = '0;
  assign div_quo[0][1] = '0;
  assign div_quo[0][2] = '0;

  for (genvar k = 0; k < CW; k++) begin : g_div
    spi_div_step #(.CW(CW), .RW(RW), .BIT(CW - 1 - k)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (div_valid[k]),
      .ready_o (div_ready[k]),
      .kind_i  (div_kind[k]),
      .point_i (div_pt[k]),
      .den_i   (div_den[k]),
      .rem_i   (div_rem[k]),
      .quo_i   (div_quo[k]),
      .neg_i   (div_neg[k]),
      .valid_o (div_valid[k+1]),
      .ready_i (div_ready[k+1]),
      .kind_o  (div_kind[k+1]),
      .point_o (div_pt[k+1]),
      .den_o   (div_den[k+1]),
      .rem_o   (div_rem[k+1]),
      .quo_o   (div_quo[k+1]),
      .neg_o   (div_neg[k+1])
    );
  end

  logic                 out_valid_q, out_en;
  spi_pkg::hit_kind_e   out_kind_q;
  logic signed [CW-1:0] out_pt_q [3];

  assign out_en        = !out_valid_q || !out_stall_i;
  assign div_ready[CW] = out_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= div_valid[CW];
    end
  end

  // A crossing takes the signed quotient; the other kinds keep their point.
  always_ff @(posedge clk_i) begin
    if (out_en) begin
      out_kind_q <= div_kind[CW];
      for (int i = 0; i < 3; i++) begin
        if (div_kind[CW] == spi_pkg::HIT_CROSS) begin
          out_pt_q[i] <= div_neg[CW][i] ? $signed(~div_quo[CW][i] + 1'b1)
                                        : $signed(div_quo[CW][i]);
        end else begin
          out_pt_q[i] <= div_pt[CW][i];
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_kind_o  = out_kind_q;
  assign point_x_o   = out_pt_q[0];
  assign point_y_o   = out_pt_q[1];
  assign point_z_o   = out_pt_q[2];

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import spi_pkg::*;

  localparam int CW      = COORD_WIDTH;
  localparam int FB      = FRAC_BITS;
  localparam int LATENCY = CW + 7;
  localparam int N_RAND  = 550;
  localparam longint CYCLE_LIMIT = 400000;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t sx, sy, sz, ex, ey, ez;
  } segment_t;

  typedef struct packed {
    hit_kind_e kind;
    coord_t    px, py, pz;
  } crossing_t;

  // Directed rows: the expected result is typed in only when check_row is set.
  typedef struct {
    segment_t  seg;
    logic      check_row;
    crossing_t want;
  } seg_row_t;

  logic clk_i, rst_ni;
  logic cfg_valid_i, cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [CW-1:0] cfg_data_i;
  logic in_valid_i, in_stall_o;
  coord_t start_x_i, start_y_i, start_z_i, end_x_i, end_y_i, end_z_i;
  logic out_valid_o, out_stall_i;
  logic [1:0] hit_kind_o;
  coord_t point_x_o, point_y_o, point_z_o;

  segment_plane_intersection_unit dut (.*);

  coord_t nrm_x, nrm_y, nrm_z, pl_off;

  crossing_t expected_hits[$];
  int  mismatches;
  longint cycle_count;
  bit  stimulus_done;
  bit  sending;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Signed plane distance at full precision (offset raised by FB bits).
  function automatic logic signed [127:0] plane_distance(coord_t x, coord_t y, coord_t z);
    logic signed [127:0] d;
    d = 128'(signed'(pl_off)) <<< FB;
    d = d + 128'(signed'(nrm_x)) * 128'(signed'(x));
    d = d + 128'(signed'(nrm_y)) * 128'(signed'(y));
    d = d + 128'(signed'(nrm_z)) * 128'(signed'(z));
    return d;
  endfunction

  function automatic coord_t blend_axis(logic signed [127:0] ns, logic signed [127:0] ne,
                                        coord_t s, coord_t e);
    logic signed [255:0] num, den, q;
    logic neg;
    num = 256'(ns) * 256'(signed'(e)) + 256'(ne) * 256'(signed'(s));
    den = 256'(ns) + 256'(ne);
    neg = num < 0;
    if (neg) num = -num;
    q = num / den;
    if (neg) q = -q;
    return q[CW-1:0];
  endfunction

  function automatic crossing_t predict_crossing(segment_t g);
    crossing_t r;
    logic signed [127:0] ds, de, ns, ne;
    ds = plane_distance(g.sx, g.sy, g.sz);
    de = plane_distance(g.ex, g.ey, g.ez);
    r = '0;
    if (ds != 0 && de != 0 && ((ds < 0) == (de < 0))) begin
      r.kind = HIT_NONE;
    end else if (ds == 0) begin
      r = '{HIT_START, g.sx, g.sy, g.sz};
    end else if (de == 0) begin
      r = '{HIT_END, g.ex, g.ey, g.ez};
    end else begin
      ns = ds < 0 ? -ds : ds;
      ne = de < 0 ? -de : de;
      r.kind = HIT_CROSS;
      r.px = blend_axis(ns, ne, g.sx, g.ex);
      r.py = blend_axis(ns, ne, g.sy, g.ey);
      r.pz = blend_axis(ns, ne, g.sz, g.ez);
    end
    return r;
  endfunction

  // Leaves valid high so that writes can follow back to back.
  task automatic write_plane_reg(cfg_reg_e idx, coord_t val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_NORMAL_X: nrm_x = val;
      REG_NORMAL_Y: nrm_y = val;
      REG_NORMAL_Z: nrm_z = val;
      default:      pl_off = val;
    endcase
  endtask

  task automatic set_plane(coord_t x, coord_t y, coord_t z, coord_t o);
    write_plane_reg(REG_NORMAL_X, x);
    write_plane_reg(REG_NORMAL_Y, y);
    write_plane_reg(REG_NORMAL_Z, z);
    write_plane_reg(REG_OFFSET, o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain_results();
    while (expected_hits.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // Offers one segment and holds it until the transfer happens.
  task automatic send_segment(segment_t g, crossing_t want);
    in_valid_i <= 1'b1;
    {start_x_i, start_y_i, start_z_i, end_x_i, end_y_i, end_z_i} <= g;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_hits = {expected_hits, want};
  endtask

  task automatic idle_gap();
    int n;
    n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
    if (n != 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'($urandom);
      1: return coord_t'(signed'($urandom_range(0, 2000)) - 1000) <<< FB;
      2: return $urandom_range(0, 1) ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      default: return coord_t'(signed'($urandom_range(0, 200000)) - 100000) <<< 4;
    endcase
  endfunction

  function automatic segment_t rand_segment();
    segment_t g;
    g = {rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord()};
    // Flip the z sign often so the default-like planes see many crossings.
    if ($urandom_range(0, 1) && g.sz != 0) g.ez = -g.sz + coord_t'($urandom_range(0, 255));
    // Put an endpoint exactly on a z plane now and then.
    if ($urandom_range(0, 9) == 0) g.sz = 0;
    if ($urandom_range(0, 9) == 0) g.ez = 0;
    return g;
  endfunction

  localparam coord_t ONE  = coord_t'(1) <<< FB;
  localparam coord_t MAXC = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t MINC = {1'b1, {(CW-1){1'b0}}};

  seg_row_t directed_rows[] = '{
    '{'{0, 0, 0, 0, 0, 0}, 1'b1, '{HIT_START, 0, 0, 0}},
    '{'{ONE, 2*ONE, ONE, 3, 4, 5}, 1'b1, '{HIT_NONE, 0, 0, 0}},
    '{'{ONE, 2*ONE, ONE, 7, 8, 0}, 1'b1, '{HIT_END, 7, 8, 0}},
    '{'{5, 6, 0, 7, 8, 0}, 1'b1, '{HIT_START, 5, 6, 0}},
    '{'{0, 0, -ONE, 0, 0, ONE}, 1'b1, '{HIT_CROSS, 0, 0, 0}},
    '{'{MAXC, MINC, MAXC, MINC, MAXC, MINC}, 1'b0, '{HIT_NONE, 0, 0, 0}},
    '{'{MINC, MINC, MINC, MAXC, MAXC, MAXC}, 1'b0, '{HIT_NONE, 0, 0, 0}},
    '{'{MAXC, MAXC, MAXC, MAXC, MAXC, MAXC}, 1'b1, '{HIT_NONE, 0, 0, 0}},
    '{'{MINC, MINC, MINC, MINC, MINC, MINC}, 1'b1, '{HIT_NONE, 0, 0, 0}},
    '{'{-1, 3, -3*ONE, 1, -3, ONE}, 1'b0, '{HIT_NONE, 0, 0, 0}},
    '{'{10*ONE, -ONE, -1, -10*ONE, ONE, 2}, 1'b0, '{HIT_NONE, 0, 0, 0}}
  };

  task automatic run_random(int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && count > 0) begin
        segment_t g;
        g = rand_segment();
        send_segment(g, predict_crossing(g));
        burst--;
        count--;
      end
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1'b0;
  endtask

  // Stimulus.
  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    in_valid_i = 1'b0;
    {start_x_i, start_y_i, start_z_i, end_x_i, end_y_i, end_z_i} = '0;
    nrm_x = '0; nrm_y = '0; nrm_z = ONE; pl_off = '0;
    stimulus_done = 1'b0;
    sending = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset plane: z = 0.
    foreach (directed_rows[i]) begin
      send_segment(directed_rows[i].seg, directed_rows[i].check_row ?
                   directed_rows[i].want : predict_crossing(directed_rows[i].seg));
      idle_gap();
    end
    in_valid_i <= 1'b0;
    drain_results();

    // Zero normal with zero offset: every start counts as in the plane.
    set_plane(0, 0, 0, 0);
    send_segment('{ONE, 2, 3, 4, 5, 6}, '{HIT_START, ONE, 2, 3});
    in_valid_i <= 1'b0;
    drain_results();
    // Zero normal with an offset: never a hit.
    set_plane(0, 0, 0, MAXC);
    send_segment('{ONE, 2, 3, 4, 5, 6}, '{HIT_NONE, 0, 0, 0});
    in_valid_i <= 1'b0;
    drain_results();

    // Random phases over several planes, extremes among them.
    sending = 1'b1;
    set_plane(0, 0, ONE, 0);
    run_random(140);
    drain_results();
    set_plane(MAXC, MINC, MAXC, MINC);
    run_random(70);
    drain_results();
    set_plane(ONE, -ONE, ONE/2, -3*ONE);
    run_random(140);
    drain_results();
    set_plane(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
    run_random(70);
    drain_results();
    set_plane(0, 0, -2*ONE, 5*ONE);
    run_random(130);
    drain_results();
    stimulus_done = 1'b1;
  end

  // Receiver stall pattern, with one long hold-off during the first random phase.
  initial begin
    out_stall_i = 1'b0;
    wait (sending);
    repeat (10) @(posedge clk_i);
    out_stall_i <= 1'b1;
    repeat (3 * LATENCY) @(posedge clk_i);
    out_stall_i <= 1'b0;
    forever begin
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      out_stall_i <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  // Result checking.
  always @(posedge clk_i) begin
    crossing_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer kind=%0d", hit_kind_o);
      end else begin
        w = expected_hits.pop_front();
        if (hit_kind_o !== w.kind || point_x_o !== w.px || point_y_o !== w.py ||
            point_z_o !== w.pz) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d (%0d,%0d,%0d) got %0d (%0d,%0d,%0d)",
                     w.kind, w.px, w.py, w.pz, hit_kind_o, point_x_o, point_y_o, point_z_o);
        end
      end
    end
  end

  // End of run and watchdog.
  initial begin
    mismatches = 0;
    cycle_count = 0;
    while (!stimulus_done && cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    if (!stimulus_done) begin
      $display("FAILURE");
      $finish;
    end else begin
      if (mismatches == 0 && expected_hits.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
    end
  end

endmodule
